@@ rtl/cpsc_pkg.sv @@
`default_nettype none

package cpsc_pkg;

  localparam int unsigned STYLE_W    = 12;
  localparam int unsigned TONE_W     = 8;
  localparam int unsigned NEAR_N     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [TONE_W-1:0] TONE_NONE    = 8'd255;
  localparam logic [2:0]        FINGER_LIMIT = 3'd2;

  typedef enum logic [1:0] {
    TASK_BRUSH      = 2'd0,
    TASK_ERASE      = 2'd1,
    TASK_PAINTBRUSH = 2'd2,
    TASK_FINGER     = 2'd3
  } task_mode_t;

  typedef enum logic [1:0] {
    KIND_INK       = 2'd0,
    KIND_PAINT     = 2'd1,
    KIND_INK_PAINT = 2'd2
  } color_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TASK_MODE      = 3'd0,
    CFG_COLOR_KIND     = 3'd1,
    CFG_SELECTIVE      = 3'd2,
    CFG_LOCK_ALPHA     = 3'd3,
    CFG_KEEP_ANTIALIAS = 3'd4,
    CFG_SELECTED_STYLE = 3'd5,
    CFG_PALETTE_ORDER  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    task_mode_t         task_mode;
    color_kind_t        color_kind;
    logic               selective;
    logic               lock_alpha;
    logic               keep_antialias;
    logic [STYLE_W-1:0] selected_style;
    logic               palette_order;
  } cfg_t;

  typedef struct packed {
    logic [STYLE_W-1:0]        brush_ink;
    logic [TONE_W-1:0]         brush_tone;
    logic [STYLE_W-1:0]        old_ink;
    logic [STYLE_W-1:0]        old_paint;
    logic [TONE_W-1:0]         old_tone;
    logic                      old_ink_above;
    logic                      at_edge;
    logic [NEAR_N*TONE_W-1:0]  near_tones;
    logic [NEAR_N*STYLE_W-1:0] near_inks;
  } in_t;

  typedef struct packed {
    logic [STYLE_W-1:0] new_ink;
    logic [STYLE_W-1:0] new_paint;
    logic [TONE_W-1:0]  new_tone;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/colormap_pixel_stroke_compositor_core.sv @@
// an input transfer passes the input register, then the result register, to out_data;
// one pixel per cycle sustained while out_stall stays low
// in_stall rises only when both stages hold pixels and out_stall is high
// reset (rst_n low, synchronous) empties both stages and clears all
// configuration registers to 0
`default_nettype none

module colormap_pixel_stroke_compositor_core (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [cpsc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [cpsc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire cpsc_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output cpsc_pkg::out_t                        out_data
);

  cpsc_pkg::cfg_t cfg_r;
  cpsc_pkg::in_t  pix_r;
  logic           pix_valid_r;
  logic           out_valid_r;
  cpsc_pkg::out_t out_data_r;
  cpsc_pkg::out_t res_nxt;
  logic           out_load;
  logic           in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cpsc_pkg::cfg_index_t'(cfg_index))
        cpsc_pkg::CFG_TASK_MODE:      cfg_r.task_mode <= cpsc_pkg::task_mode_t'(cfg_data[1:0]);
        cpsc_pkg::CFG_COLOR_KIND:     cfg_r.color_kind <= cpsc_pkg::color_kind_t'(cfg_data[1:0]);
        cpsc_pkg::CFG_SELECTIVE:      cfg_r.selective <= cfg_data[0];
        cpsc_pkg::CFG_LOCK_ALPHA:     cfg_r.lock_alpha <= cfg_data[0];
        cpsc_pkg::CFG_KEEP_ANTIALIAS: cfg_r.keep_antialias <= cfg_data[0];
        cpsc_pkg::CFG_SELECTED_STYLE: cfg_r.selected_style <= cfg_data;
        cpsc_pkg::CFG_PALETTE_ORDER:  cfg_r.palette_order <= cfg_data[0];
        default:                      cfg_r <= cfg_r;
      endcase
    end
  end

  assign out_load = pix_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = pix_valid_r && out_valid_r && out_stall;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_load) begin
        pix_valid_r <= 1'b1;
      end else if (out_load) begin
        pix_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      pix_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

  cpsc_kernel u_kernel (
    .cfg (cfg_r),
    .pix (pix_r),
    .res (res_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/cpsc_kernel.sv @@
`default_nettype none

module cpsc_kernel (
  input  wire cpsc_pkg::cfg_t cfg,
  input  wire cpsc_pkg::in_t  pix,
  output cpsc_pkg::out_t      res
);

  function automatic logic [cpsc_pkg::TONE_W-1:0] erase_tone(
    input cpsc_pkg::cfg_t                 c,
    input logic [cpsc_pkg::TONE_W-1:0]    bt,
    input logic [cpsc_pkg::STYLE_W-1:0]   oink,
    input logic [cpsc_pkg::TONE_W-1:0]    ot
  );
    logic [cpsc_pkg::TONE_W-1:0] t;
    logic [cpsc_pkg::TONE_W-1:0] r;
    t = cpsc_pkg::TONE_NONE - bt;
    r = ot;
    if (!c.selective || oink == c.selected_style) begin
      if (!c.keep_antialias) begin
        if (bt == '0) r = cpsc_pkg::TONE_NONE;
      end else if (bt < cpsc_pkg::TONE_NONE) begin
        r = (ot > t) ? ot : t;
      end
    end
    return r;
  endfunction

  logic [cpsc_pkg::TONE_W-1:0]  near_t [cpsc_pkg::NEAR_N];
  logic [cpsc_pkg::STYLE_W-1:0] near_i [cpsc_pkg::NEAR_N];
  logic [2:0]                   fill_cnt;
  logic [2:0]                   trim_cnt;
  logic [cpsc_pkg::TONE_W-1:0]  fill_min;
  logic [cpsc_pkg::TONE_W-1:0]  trim_max;
  logic                         paint_change;
  logic                         paint_match;

  // unpack neighbours: left, right, top, bottom
  always_comb begin
    for (int k = 0; k < cpsc_pkg::NEAR_N; k++) begin
      near_t[k] = pix.near_tones[k*cpsc_pkg::TONE_W +: cpsc_pkg::TONE_W];
      near_i[k] = pix.near_inks[k*cpsc_pkg::STYLE_W +: cpsc_pkg::STYLE_W];
    end
  end

  // hole fill: neighbours darker than this pixel
  always_comb begin
    fill_cnt = '0;
    fill_min = pix.old_tone;
    for (int k = 0; k < cpsc_pkg::NEAR_N; k++) begin
      if (near_t[k] < pix.old_tone) begin
        fill_cnt = fill_cnt + 3'd1;
        if (near_t[k] < fill_min) fill_min = near_t[k];
      end
    end
  end

  // protrusion trim: neighbours of other ink or lighter tone
  always_comb begin
    trim_cnt = '0;
    trim_max = pix.old_tone;
    for (int k = 0; k < cpsc_pkg::NEAR_N; k++) begin
      if (near_i[k] != pix.brush_ink) begin
        trim_cnt = trim_cnt + 3'd1;
        trim_max = cpsc_pkg::TONE_NONE;
      end else if (near_t[k] > pix.old_tone) begin
        trim_cnt = trim_cnt + 3'd1;
        if (near_t[k] > trim_max) trim_max = near_t[k];
      end
    end
  end

  assign paint_match  = !cfg.selective || pix.old_paint == cfg.selected_style;
  assign paint_change = (!cfg.selective && !cfg.lock_alpha) ||
                        (cfg.selective && pix.old_paint == '0) ||
                        (cfg.lock_alpha && pix.old_paint != '0);

  always_comb begin
    res.new_ink   = pix.old_ink;
    res.new_paint = pix.old_paint;
    res.new_tone  = pix.old_tone;
    unique case (cfg.task_mode)
      cpsc_pkg::TASK_BRUSH: begin
        if (pix.brush_tone == '0 && !cfg.selective && !cfg.lock_alpha) begin
          res.new_ink  = pix.brush_ink;
          res.new_tone = pix.brush_tone;
        end else if (cfg.lock_alpha && pix.old_tone == cpsc_pkg::TONE_NONE &&
                     pix.old_paint == '0) begin
          res.new_tone = pix.old_tone;
        end else if (pix.old_tone == '0 && cfg.selective &&
                     (!cfg.palette_order || pix.old_ink_above)) begin
          res.new_tone = pix.old_tone;
        end else if (pix.brush_tone <= pix.old_tone) begin
          res.new_ink  = pix.brush_ink;
          res.new_tone = cfg.lock_alpha ? pix.old_tone : pix.brush_tone;
        end
      end
      cpsc_pkg::TASK_ERASE: begin
        case (cfg.color_kind)
          cpsc_pkg::KIND_INK: begin
            res.new_tone = erase_tone(cfg, pix.brush_tone, pix.old_ink, pix.old_tone);
          end
          cpsc_pkg::KIND_PAINT: begin
            if (pix.brush_tone == '0 && paint_match) res.new_paint = '0;
          end
          cpsc_pkg::KIND_INK_PAINT: begin
            if (pix.brush_tone < cpsc_pkg::TONE_NONE && paint_match) res.new_paint = '0;
            res.new_tone = erase_tone(cfg, pix.brush_tone, pix.old_ink, pix.old_tone);
          end
          default: res.new_tone = pix.old_tone;
        endcase
      end
      cpsc_pkg::TASK_PAINTBRUSH: begin
        if (pix.brush_tone == '0) begin
          case (cfg.color_kind)
            cpsc_pkg::KIND_INK: res.new_ink = pix.brush_ink;
            cpsc_pkg::KIND_INK_PAINT: begin
              res.new_ink = pix.brush_ink;
              if (paint_change) res.new_paint = pix.brush_ink;
            end
            default: res.new_ink = pix.old_ink;
          endcase
        end
      end
      cpsc_pkg::TASK_FINGER: begin
        if (!pix.at_edge && pix.brush_ink != '0) begin
          if (!cfg.selective) begin
            if (fill_cnt > cpsc_pkg::FINGER_LIMIT) begin
              res.new_ink  = pix.brush_ink;
              res.new_tone = fill_min;
            end
          end else if (pix.old_tone != cpsc_pkg::TONE_NONE &&
                       pix.old_ink == pix.brush_ink) begin
            if (trim_cnt > cpsc_pkg::FINGER_LIMIT) begin
              res.new_ink  = (trim_max == cpsc_pkg::TONE_NONE) ? '0 : pix.brush_ink;
              res.new_tone = trim_max;
            end
          end
        end
      end
      default: res.new_tone = pix.old_tone;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/cpsc_checker.sv @@
`default_nettype none

module cpsc_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire cpsc_pkg::out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side stalls only behind a blocked full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty pipeline cannot stall the input
  a_empty_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("stall while output empty");

endmodule

bind colormap_pixel_stroke_compositor_core cpsc_checker u_cpsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ dv/tb_colormap_pixel_stroke_compositor_core.sv @@
`timescale 1ns / 100ps

module tb_colormap_pixel_stroke_compositor_core;

  localparam cpsc_pkg::color_kind_t KIND_NONE = cpsc_pkg::color_kind_t'(2'd3);
  localparam int NUM_REGS = 7;
  localparam int SEGMENTS = 7;
  localparam int SEG_ITEMS = 84;

  typedef struct {
    cpsc_pkg::cfg_t cfg;
    cpsc_pkg::in_t  px;
    bit             pinned;
    cpsc_pkg::out_t want;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  cpsc_pkg::cfg_index_t            cfg_index = cpsc_pkg::CFG_TASK_MODE;
  logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  cpsc_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  cpsc_pkg::out_t                  out_data;

  cpsc_pkg::cfg_t model_cfg = '0;
  cpsc_pkg::out_t pending_pixels[$];
  row_t           directed_rows[$];
  bit             pin_on = 1'b0;
  cpsc_pkg::out_t pin_want = '0;
  int             send_idle_pct = 18;
  int             recv_idle_pct = 78;
  int             n_mismatch = 0;

  colormap_pixel_stroke_compositor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [cpsc_pkg::TONE_W-1:0] erased_tone(cpsc_pkg::cfg_t c,
                                                              cpsc_pkg::in_t p);
    logic [cpsc_pkg::TONE_W-1:0] floor_tone;
    if (c.selective && p.old_ink != c.selected_style) return p.old_tone;
    if (!c.keep_antialias) return (p.brush_tone == 0) ? cpsc_pkg::TONE_NONE : p.old_tone;
    if (p.brush_tone == cpsc_pkg::TONE_NONE) return p.old_tone;
    floor_tone = cpsc_pkg::TONE_NONE - p.brush_tone;
    return (p.old_tone > floor_tone) ? p.old_tone : floor_tone;
  endfunction

  function automatic cpsc_pkg::out_t composite_pixel(cpsc_pkg::cfg_t c, cpsc_pkg::in_t p);
    cpsc_pkg::out_t               r;
    logic                         paint_ok;
    logic                         recolor;
    int                           hits;
    logic [cpsc_pkg::TONE_W-1:0]  t;
    logic [cpsc_pkg::TONE_W-1:0]  best;
    logic [cpsc_pkg::STYLE_W-1:0] nb;
    r.new_ink   = p.old_ink;
    r.new_paint = p.old_paint;
    r.new_tone  = p.old_tone;
    hits = 0;
    case (c.task_mode)
      cpsc_pkg::TASK_BRUSH: begin
        if (p.brush_tone == 0 && !c.selective && !c.lock_alpha) begin
          r.new_ink  = p.brush_ink;
          r.new_tone = '0;
        end else if (c.lock_alpha && p.old_tone == cpsc_pkg::TONE_NONE &&
                     p.old_paint == 0) begin
          // empty pixel under alpha lock
        end else if (p.old_tone == 0 && c.selective &&
                     (!c.palette_order || p.old_ink_above)) begin
          // protected ink
        end else if (p.brush_tone <= p.old_tone) begin
          r.new_ink  = p.brush_ink;
          r.new_tone = c.lock_alpha ? p.old_tone : p.brush_tone;
        end
      end
      cpsc_pkg::TASK_ERASE: begin
        paint_ok = !c.selective || p.old_paint == c.selected_style;
        case (c.color_kind)
          cpsc_pkg::KIND_INK: r.new_tone = erased_tone(c, p);
          cpsc_pkg::KIND_PAINT: if (p.brush_tone == 0 && paint_ok) r.new_paint = '0;
          cpsc_pkg::KIND_INK_PAINT: begin
            if (p.brush_tone != cpsc_pkg::TONE_NONE && paint_ok) r.new_paint = '0;
            r.new_tone = erased_tone(c, p);
          end
          default: ;
        endcase
      end
      cpsc_pkg::TASK_PAINTBRUSH: if (p.brush_tone == 0) begin
        recolor = (!c.selective && !c.lock_alpha) || (c.selective && p.old_paint == 0) ||
                  (c.lock_alpha && p.old_paint != 0);
        if (c.color_kind == cpsc_pkg::KIND_INK) begin
          r.new_ink = p.brush_ink;
        end else if (c.color_kind == cpsc_pkg::KIND_INK_PAINT) begin
          r.new_ink = p.brush_ink;
          if (recolor) r.new_paint = p.brush_ink;
        end
      end
      default: if (!p.at_edge && p.brush_ink != 0) begin
        best = p.old_tone;
        if (!c.selective) begin
          // hole fill
          for (int k = 0; k < cpsc_pkg::NEAR_N; k++) begin
            t = p.near_tones[8*k +: 8];
            if (t < p.old_tone) begin
              hits++;
              if (t < best) best = t;
            end
          end
          if (hits > cpsc_pkg::FINGER_LIMIT) begin
            r.new_ink  = p.brush_ink;
            r.new_tone = best;
          end
        end else if (p.old_tone != cpsc_pkg::TONE_NONE && p.old_ink == p.brush_ink) begin
          // protrusion trim
          for (int k = 0; k < cpsc_pkg::NEAR_N; k++) begin
            t  = p.near_tones[8*k +: 8];
            nb = p.near_inks[12*k +: 12];
            if (nb != p.brush_ink) begin
              hits++;
              best = cpsc_pkg::TONE_NONE;
            end else if (t > p.old_tone) begin
              hits++;
              if (t > best) best = t;
            end
          end
          if (hits > cpsc_pkg::FINGER_LIMIT) begin
            r.new_ink  = (best == cpsc_pkg::TONE_NONE) ? '0 : p.brush_ink;
            r.new_tone = best;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic cpsc_pkg::cfg_t mk_cfg(cpsc_pkg::task_mode_t m, cpsc_pkg::color_kind_t k,
                                            bit sel, bit lock, bit aa,
                                            logic [cpsc_pkg::STYLE_W-1:0] style, bit po);
    cpsc_pkg::cfg_t c;
    c.task_mode      = m;
    c.color_kind     = k;
    c.selective      = sel;
    c.lock_alpha     = lock;
    c.keep_antialias = aa;
    c.selected_style = style;
    c.palette_order  = po;
    return c;
  endfunction

  function automatic cpsc_pkg::in_t mk_px(logic [cpsc_pkg::STYLE_W-1:0] bink,
                                          logic [cpsc_pkg::TONE_W-1:0] btone,
                                          logic [cpsc_pkg::STYLE_W-1:0] oink,
                                          logic [cpsc_pkg::STYLE_W-1:0] opaint,
                                          logic [cpsc_pkg::TONE_W-1:0] otone,
                                          bit above, bit edge_px,
                                          logic [31:0] ntones, logic [47:0] ninks);
    cpsc_pkg::in_t p;
    p.brush_ink     = bink;
    p.brush_tone    = btone;
    p.old_ink       = oink;
    p.old_paint     = opaint;
    p.old_tone      = otone;
    p.old_ink_above = above;
    p.at_edge       = edge_px;
    p.near_tones    = ntones;
    p.near_inks     = ninks;
    return p;
  endfunction

  function automatic cpsc_pkg::out_t mk_out(logic [cpsc_pkg::STYLE_W-1:0] ink,
                                            logic [cpsc_pkg::STYLE_W-1:0] paint,
                                            logic [cpsc_pkg::TONE_W-1:0] tone);
    cpsc_pkg::out_t r;
    r.new_ink   = ink;
    r.new_paint = paint;
    r.new_tone  = tone;
    return r;
  endfunction

  function automatic logic [cpsc_pkg::STYLE_W-1:0] rand_style(cpsc_pkg::cfg_t c);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return c.selected_style;
      4: return cpsc_pkg::STYLE_W'($urandom_range(1, 7));
      default: return cpsc_pkg::STYLE_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [cpsc_pkg::TONE_W-1:0] rand_tone();
    case ($urandom_range(9))
      0, 1: return '0;
      2, 3: return cpsc_pkg::TONE_NONE;
      4: return cpsc_pkg::TONE_NONE - 8'd1;
      5: return 8'd1;
      default: return cpsc_pkg::TONE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic cpsc_pkg::cfg_t rand_cfg();
    logic [cpsc_pkg::STYLE_W-1:0] style;
    case ($urandom_range(3))
      0: style = '0;
      1: style = '1;
      2: style = cpsc_pkg::STYLE_W'($urandom_range(1, 7));
      default: style = cpsc_pkg::STYLE_W'($urandom_range(4095));
    endcase
    return mk_cfg(cpsc_pkg::task_mode_t'($urandom_range(3)),
                  cpsc_pkg::color_kind_t'($urandom_range(3)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  style, 1'($urandom_range(1)));
  endfunction

  function automatic cpsc_pkg::in_t gen_pixel(cpsc_pkg::cfg_t c);
    cpsc_pkg::in_t p;
    p.brush_ink     = rand_style(c);
    p.brush_tone    = rand_tone();
    p.old_ink       = rand_style(c);
    p.old_paint     = ($urandom_range(3) == 0) ? '0 : rand_style(c);
    p.old_tone      = rand_tone();
    p.old_ink_above = 1'($urandom_range(1));
    p.at_edge       = ($urandom_range(9) == 0);
    for (int k = 0; k < cpsc_pkg::NEAR_N; k++) begin
      p.near_tones[8*k +: 8]   = rand_tone();
      p.near_inks[12*k +: 12]  = rand_style(c);
    end
    // finger strokes mostly run over a uniform ink region
    if (c.task_mode == cpsc_pkg::TASK_FINGER && $urandom_range(9) < 7) begin
      p.old_ink = p.brush_ink;
      for (int k = 0; k < cpsc_pkg::NEAR_N; k++) begin
        if ($urandom_range(99) < 85) p.near_inks[12*k +: 12] = p.brush_ink;
      end
    end
    return p;
  endfunction

  function automatic void add_row(row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  task automatic push_pixel(cpsc_pkg::in_t px, bit pinned, cpsc_pkg::out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    pin_on   <= pinned;
    pin_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(cpsc_pkg::cfg_t c);
    logic [cpsc_pkg::CFG_DATA_W-1:0] val;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (cpsc_pkg::cfg_index_t'(i))
        cpsc_pkg::CFG_TASK_MODE:      val = cpsc_pkg::CFG_DATA_W'(c.task_mode);
        cpsc_pkg::CFG_COLOR_KIND:     val = cpsc_pkg::CFG_DATA_W'(c.color_kind);
        cpsc_pkg::CFG_SELECTIVE:      val = cpsc_pkg::CFG_DATA_W'(c.selective);
        cpsc_pkg::CFG_LOCK_ALPHA:     val = cpsc_pkg::CFG_DATA_W'(c.lock_alpha);
        cpsc_pkg::CFG_KEEP_ANTIALIAS: val = cpsc_pkg::CFG_DATA_W'(c.keep_antialias);
        cpsc_pkg::CFG_SELECTED_STYLE: val = c.selected_style;
        cpsc_pkg::CFG_PALETTE_ORDER:  val = cpsc_pkg::CFG_DATA_W'(c.palette_order);
        default:                      val = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= cpsc_pkg::cfg_index_t'(i);
      cfg_data  <= val;
      @(negedge clk);
    end
    cfg_we    <= 1'b0;
    model_cfg = c;
  endtask

  // result check first, then the input transfer of the same edge
  always @(posedge clk) begin
    cpsc_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected pixel: ink %0d paint %0d tone %0d",
                   out_data.new_ink, out_data.new_paint, out_data.new_tone);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.new_ink !== want.new_ink || out_data.new_paint !== want.new_paint ||
            out_data.new_tone !== want.new_tone) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("pixel mismatch: expected ink %0d paint %0d tone %0d, got %0d %0d %0d",
                     want.new_ink, want.new_paint, want.new_tone,
                     out_data.new_ink, out_data.new_paint, out_data.new_tone);
        end
      end
    end
    if (rst_n && in_valid && !in_stall)
      pending_pixels = {pending_pixels,
                        pin_on ? pin_want : composite_pixel(model_cfg, in_data)};
  end

  initial begin
    cpsc_pkg::cfg_t c;
    cpsc_pkg::cfg_t c_reset;
    cpsc_pkg::cfg_t c_lock;
    cpsc_pkg::cfg_t c_sel;
    cpsc_pkg::cfg_t c_order;
    cpsc_pkg::cfg_t c_erase;
    cpsc_pkg::cfg_t c_erase_aa;
    cpsc_pkg::cfg_t c_erase_sel;
    cpsc_pkg::cfg_t c_fill;
    cpsc_pkg::cfg_t c_trim;
    c_reset     = '0;
    c_lock      = mk_cfg(cpsc_pkg::TASK_BRUSH, cpsc_pkg::KIND_INK, 0, 1, 0, '0, 0);
    c_sel       = mk_cfg(cpsc_pkg::TASK_BRUSH, cpsc_pkg::KIND_INK, 1, 0, 0, '0, 0);
    c_order     = mk_cfg(cpsc_pkg::TASK_BRUSH, cpsc_pkg::KIND_INK, 1, 0, 0, '0, 1);
    c_erase     = mk_cfg(cpsc_pkg::TASK_ERASE, cpsc_pkg::KIND_INK, 0, 0, 0, '0, 0);
    c_erase_aa  = mk_cfg(cpsc_pkg::TASK_ERASE, cpsc_pkg::KIND_INK, 0, 0, 1, '0, 0);
    c_erase_sel = mk_cfg(cpsc_pkg::TASK_ERASE, cpsc_pkg::KIND_INK, 1, 0, 0, '1, 0);
    c_fill      = mk_cfg(cpsc_pkg::TASK_FINGER, cpsc_pkg::KIND_INK, 0, 0, 0, '0, 0);
    c_trim      = mk_cfg(cpsc_pkg::TASK_FINGER, cpsc_pkg::KIND_INK, 1, 0, 0, '0, 0);

    // brush after reset
    add_row(row_t'{c_reset, mk_px(12'd4095, 8'd0, 12'd12, 12'd34, 8'd200,
                   0, 0, '0, '0), 1'b1, mk_out(12'd4095, 12'd34, 8'd0)});
    add_row(row_t'{c_reset, mk_px('1, '1, '1, '1, '1, 1, 1, '1, '1),
                   1'b0, '0});
    add_row(row_t'{c_reset, mk_px('0, '0, '0, '0, '0, 0, 0, '0, '0),
                   1'b1, mk_out('0, '0, '0)});
    // alpha lock
    add_row(row_t'{c_lock, mk_px(12'd9, 8'd0, 12'd3, 12'd0, 8'd255,
                   0, 0, '0, '0), 1'b1, mk_out(12'd3, 12'd0, 8'd255)});
    add_row(row_t'{c_lock, mk_px(12'd9, 8'd10, 12'd3, 12'd5, 8'd200,
                   0, 0, '0, '0), 1'b0, '0});
    // selective and palette order
    add_row(row_t'{c_sel, mk_px(12'd7, 8'd0, 12'd2, 12'd1, 8'd0,
                   0, 0, '0, '0), 1'b1, mk_out(12'd2, 12'd1, 8'd0)});
    add_row(row_t'{c_order, mk_px(12'd7, 8'd0, 12'd2, 12'd1, 8'd0,
                   0, 0, '0, '0), 1'b0, '0});
    add_row(row_t'{c_order, mk_px(12'd7, 8'd0, 12'd2, 12'd1, 8'd0,
                   1, 0, '0, '0), 1'b1, mk_out(12'd2, 12'd1, 8'd0)});
    // erase
    add_row(row_t'{c_erase, mk_px(12'd1, 8'd0, 12'd5, 12'd6, 8'd30,
                   0, 0, '0, '0), 1'b1, mk_out(12'd5, 12'd6, 8'd255)});
    add_row(row_t'{c_erase_aa, mk_px(12'd1, 8'd100, 12'd5, 12'd6, 8'd50,
                   0, 0, '0, '0), 1'b0, '0});
    add_row(row_t'{c_erase_aa, mk_px(12'd1, 8'd255, 12'd5, 12'd6, 8'd50,
                   0, 0, '0, '0), 1'b1, mk_out(12'd5, 12'd6, 8'd50)});
    add_row(row_t'{c_erase_sel, mk_px(12'd1, 8'd0, 12'd5, 12'd6, 8'd30,
                   0, 0, '0, '0), 1'b1, mk_out(12'd5, 12'd6, 8'd30)});
    add_row(row_t'{c_erase_sel, mk_px(12'd1, 8'd0, 12'd4095, 12'd6, 8'd30,
                   0, 0, '0, '0), 1'b1, mk_out(12'd4095, 12'd6, 8'd255)});
    add_row(row_t'{mk_cfg(cpsc_pkg::TASK_ERASE, cpsc_pkg::KIND_PAINT, 0, 0, 0, '0, 0),
                   mk_px(12'd1, 8'd0, 12'd5, 12'd77, 8'd30, 0, 0, '0, '0),
                   1'b1, mk_out(12'd5, 12'd0, 8'd30)});
    add_row(row_t'{mk_cfg(cpsc_pkg::TASK_ERASE, cpsc_pkg::KIND_INK_PAINT, 0, 0, 1, '0, 0),
                   mk_px(12'd1, 8'd254, 12'd5, 12'd9, 8'd0, 0, 0, '0, '0),
                   1'b0, '0});
    add_row(row_t'{mk_cfg(cpsc_pkg::TASK_ERASE, KIND_NONE, 0, 0, 0, '0, 0),
                   mk_px(12'd1, 8'd0, 12'd5, 12'd9, 8'd30, 0, 0, '0, '0),
                   1'b1, mk_out(12'd5, 12'd9, 8'd30)});
    // paintbrush
    add_row(row_t'{mk_cfg(cpsc_pkg::TASK_PAINTBRUSH, cpsc_pkg::KIND_INK, 0, 0, 0, '0, 0),
                   mk_px(12'd300, 8'd0, 12'd1, 12'd2, 8'd40, 0, 0, '0, '0),
                   1'b1, mk_out(12'd300, 12'd2, 8'd40)});
    add_row(row_t'{mk_cfg(cpsc_pkg::TASK_PAINTBRUSH, cpsc_pkg::KIND_PAINT, 0, 0, 0, '0, 0),
                   mk_px(12'd300, 8'd0, 12'd1, 12'd2, 8'd40, 0, 0, '0, '0),
                   1'b1, mk_out(12'd1, 12'd2, 8'd40)});
    add_row(row_t'{mk_cfg(cpsc_pkg::TASK_PAINTBRUSH, cpsc_pkg::KIND_INK_PAINT, 0, 1, 0, '0,
                          0),
                   mk_px(12'd300, 8'd0, 12'd1, 12'd2, 8'd40, 0, 0, '0, '0),
                   1'b0, '0});
    add_row(row_t'{mk_cfg(cpsc_pkg::TASK_PAINTBRUSH, KIND_NONE, 0, 0, 0, '0, 0),
                   mk_px(12'd300, 8'd0, 12'd1, 12'd2, 8'd40, 0, 0, '0, '0),
                   1'b1, mk_out(12'd1, 12'd2, 8'd40)});
    // finger
    add_row(row_t'{c_fill, mk_px(12'd8, 8'd0, 12'd3, 12'd4, 8'd200, 0, 1,
                   32'hFA1E140A, '0), 1'b1, mk_out(12'd3, 12'd4, 8'd200)});
    add_row(row_t'{c_fill, mk_px(12'd0, 8'd0, 12'd3, 12'd4, 8'd200, 0, 0,
                   32'hFA1E140A, '0), 1'b1, mk_out(12'd3, 12'd4, 8'd200)});
    add_row(row_t'{c_fill, mk_px(12'd8, 8'd0, 12'd3, 12'd4, 8'd200, 0, 0,
                   32'hFA1E140A, '0), 1'b0, '0});
    add_row(row_t'{c_trim, mk_px(12'd7, 8'd0, 12'd7, 12'd4, 8'd50, 0, 0,
                   32'h0AC89664, 48'h007007007007), 1'b0, '0});
    add_row(row_t'{c_trim, mk_px(12'd7, 8'd0, 12'd7, 12'd4, 8'd50, 0, 0,
                   32'h0AC89664, 48'h007007007005), 1'b0, '0});
    add_row(row_t'{c_trim, mk_px('1, '0, '1, '1, 8'd254, 0, 0, '1, '1),
                   1'b0, '0});

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != model_cfg) begin
        settle();
        write_cfg(directed_rows[i].cfg);
      end
      push_pixel(directed_rows[i].px, directed_rows[i].pinned, directed_rows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        settle();
        if (phase == 0 && seg == 0)
          c = mk_cfg(cpsc_pkg::TASK_FINGER, KIND_NONE, 1, 1, 1, '1, 1);
        else c = rand_cfg();
        write_cfg(c);
        repeat (SEG_ITEMS) push_pixel(gen_pixel(model_cfg), 1'b0, '0);
      end
    end

    settle();
    repeat (6) @(negedge clk);
    if (n_mismatch == 0 && pending_pixels.size() == 0) begin
      $display("tb_colormap_pixel_stroke_compositor_core OK");
    end else begin
      $display("tb_colormap_pixel_stroke_compositor_core NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_colormap_pixel_stroke_compositor_core NOT OK");
    $finish;
  end

endmodule
